/* rtl/tlsdp_pkg.sv */
// Types, register indexes and the saturating add for the two-line scheduling
// block; the types are shared with its checker. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tlsdp_pkg;

  localparam int unsigned CostW  = 24;
  localparam int unsigned FieldW = 16;
  localparam int unsigned StaW   = 6;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [CostW-1:0] CostMax = {CostW{1'b1}};

  localparam logic [CfgIdxW-1:0] RegEntry1 = 8'd0;
  localparam logic [CfgIdxW-1:0] RegEntry2 = 8'd1;
  localparam logic [CfgIdxW-1:0] RegExit1  = 8'd2;
  localparam logic [CfgIdxW-1:0] RegExit2  = 8'd3;

  localparam logic [1:0] LineNone = 2'd0;

  typedef struct packed {
    logic [FieldW-1:0] station_cost_line1;
    logic [FieldW-1:0] station_cost_line2;
    logic [FieldW-1:0] move_from_line1;
    logic [FieldW-1:0] move_from_line2;
    logic              final_station;
  } item_t;

  typedef struct packed {
    logic [CostW-1:0] best_total;
    logic [1:0]       chosen_line;
    logic [StaW-1:0]  station_number;
    logic             run_end;
  } result_t;

  function automatic logic [CostW-1:0] sat_add(input logic [CostW-1:0] a,
                                                input logic [CostW-1:0] b);
    logic [CostW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CostW] ? CostMax : s[CostW-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/two_line_schedule_dp.sv */
// Two-line assembly scheduling: forward pass per station, then traceback.
// One station request per cycle is taken during the forward pass.
// After the last station the exit totals are formed, the traceback walks the
// predecessor memory back to the first station, then the cost result and each
// line result follow (path memory read, then output load).
// Reset: config, running costs and counter clear; the memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module two_line_schedule_dp #(
  parameter int unsigned MAX_STATIONS = 32
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [tlsdp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire  [tlsdp_pkg::FieldW-1:0]     cfg_data_i,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  tlsdp_pkg::item_t                 in_req_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output tlsdp_pkg::result_t               out_req_o
);
  import tlsdp_pkg::*;

  localparam int unsigned AW = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
  localparam logic [AW-1:0] LastIdx = AW'(MAX_STATIONS - 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_FIN  = 7'b0000010,
    S_TBR  = 7'b0000100,
    S_TB   = 7'b0001000,
    S_COST = 7'b0010000,
    S_RD   = 7'b0100000,
    S_LD   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [FieldW-1:0] entry1_q, entry2_q, exit1_q, exit2_q;
  logic [CostW-1:0]  run1_q, run1_d, run2_q, run2_d;
  logic [AW-1:0]     cnt_q, cnt_d;
  logic [AW-1:0]     last_q, last_d;
  logic [AW-1:0]     tb_k_q, tb_k_d;
  logic [AW-1:0]     em_k_q, em_k_d;
  logic [CostW-1:0]  best_q, best_d;
  logic              line_q, line_d;
  logic              out_valid_q, out_valid_d;
  result_t           out_q, out_d;

  logic [1:0] pred_mem [MAX_STATIONS];
  logic       path_mem [MAX_STATIONS];
  logic [1:0] pred_rd_q;
  logic       path_rd_q;
  logic [AW-1:0] pred_raddr;
  logic       pred_we, path_we, path_re;
  logic [1:0] pred_wdata;

  logic in_acc, slot_free, is_final;
  logic [CostW-1:0] c1, c2, m1, m2;
  logic [CostW-1:0] stay1, move1, stay2, move2, n1, n2, t1, t2;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  assign c1 = CostW'(in_req_i.station_cost_line1);
  assign c2 = CostW'(in_req_i.station_cost_line2);
  assign m1 = CostW'(in_req_i.move_from_line1);
  assign m2 = CostW'(in_req_i.move_from_line2);
  assign is_final = in_req_i.final_station || (cnt_q == LastIdx);

  always_comb begin
    stay1 = sat_add(run1_q, c1);
    move1 = sat_add(sat_add(run2_q, c1), m2);
    stay2 = sat_add(run2_q, c2);
    move2 = sat_add(sat_add(run1_q, c2), m1);
    if (cnt_q == '0) begin
      n1 = sat_add(CostW'(entry1_q), c1);
      n2 = sat_add(CostW'(entry2_q), c2);
      pred_wdata = 2'b00;
    end else begin
      n1 = (stay1 <= move1) ? stay1 : move1;
      n2 = (stay2 <= move2) ? stay2 : move2;
      pred_wdata = {stay2 > move2, stay1 > move1};
    end
    t1 = sat_add(run1_q, CostW'(exit1_q));
    t2 = sat_add(run2_q, CostW'(exit2_q));
  end

  always_comb begin
    state_d     = state_q;
    run1_d      = run1_q;
    run2_d      = run2_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    tb_k_d      = tb_k_q;
    em_k_d      = em_k_q;
    best_d      = best_q;
    line_d      = line_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    pred_we     = 1'b0;
    path_we     = 1'b0;
    path_re     = 1'b0;
    pred_raddr  = tb_k_q - AW'(1);
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          pred_we = 1'b1;
          run1_d  = n1;
          run2_d  = n2;
          if (is_final) begin
            last_d  = cnt_q;
            cnt_d   = '0;
            state_d = S_FIN;
          end else begin
            cnt_d = cnt_q + AW'(1);
          end
        end
      end
      S_FIN: begin
        best_d  = (t1 <= t2) ? t1 : t2;
        line_d  = !(t1 <= t2);
        run1_d  = '0;
        run2_d  = '0;
        state_d = S_TBR;
      end
      S_TBR: begin
        pred_raddr = last_q;
        tb_k_d     = last_q;
        state_d    = S_TB;
      end
      S_TB: begin
        path_we = 1'b1;
        line_d  = line_q ? !pred_rd_q[1] : pred_rd_q[0];
        if (tb_k_q == '0) begin
          state_d = S_COST;
        end else begin
          tb_k_d = tb_k_q - AW'(1);
        end
      end
      S_COST: begin
        if (slot_free) begin
          out_valid_d          = 1'b1;
          out_d.best_total     = best_q;
          out_d.chosen_line    = LineNone;
          out_d.station_number = '0;
          out_d.run_end        = 1'b0;
          em_k_d               = '0;
          state_d              = S_RD;
        end
      end
      S_RD: begin
        path_re = 1'b1;
        state_d = S_LD;
      end
      S_LD: begin
        if (slot_free) begin
          out_valid_d          = 1'b1;
          out_d.best_total     = '0;
          out_d.chosen_line    = {1'b0, path_rd_q} + 2'd1;
          out_d.station_number = StaW'(em_k_q) + StaW'(1);
          out_d.run_end        = (em_k_q == last_q);
          if (em_k_q == last_q) begin
            state_d = S_IDLE;
          end else begin
            em_k_d  = em_k_q + AW'(1);
            state_d = S_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pred_we) begin
      pred_mem[cnt_q] <= pred_wdata;
    end
    pred_rd_q <= pred_mem[pred_raddr];
    if (path_we) begin
      path_mem[tb_k_q] <= line_q;
    end
    if (path_re) begin
      path_rd_q <= path_mem[em_k_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      entry1_q    <= '0;
      entry2_q    <= '0;
      exit1_q     <= '0;
      exit2_q     <= '0;
      run1_q      <= '0;
      run2_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      run1_q      <= run1_d;
      run2_q      <= run2_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegEntry1: entry1_q <= cfg_data_i;
          RegEntry2: entry2_q <= cfg_data_i;
          RegExit1:  exit1_q  <= cfg_data_i;
          RegExit2:  exit2_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    tb_k_q <= tb_k_d;
    em_k_q <= em_k_d;
    best_q <= best_d;
    line_q <= line_d;
    out_q  <= out_d;
  end

endmodule

`default_nettype wire

/* rtl/tlsdp_checker.sv */
// Port-level checks for two_line_schedule_dp, bound into that module.
// Depends on tlsdp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlsdp_checker (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                in_valid_i,
  input wire                in_stall_o,
  input tlsdp_pkg::item_t   in_req_i,
  input wire                out_valid_o,
  input wire                out_stall_i,
  input tlsdp_pkg::result_t out_req_o
);
  import tlsdp_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_req_o))
    else $error("stalled result changed");

  // last station starts the traceback, so input is stalled next cycle
  a_busy_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_req_i.final_station |=> in_stall_o)
    else $error("input not stalled after last station");

  a_cost_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.chosen_line == LineNone |->
      out_req_o.station_number == '0 && !out_req_o.run_end)
    else $error("malformed cost result");

  a_line_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.chosen_line != LineNone |->
      out_req_o.best_total == '0 && out_req_o.station_number != '0 &&
      out_req_o.chosen_line != 2'd3)
    else $error("malformed line result");

endmodule

bind two_line_schedule_dp tlsdp_checker u_tlsdp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_req_i   (in_req_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_req_o  (out_req_o)
);

`default_nettype wire
